@@ src/spsb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spsb_pkg: shared types and constants of the scaled sprite blitter
// Sizes, register indexes and the pipeline side-band record.
// ---------------------------------------------------------------------------
package spsb_pkg;

   localparam int TEXEL_DEPTH   = 4096;
   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 768;

   localparam int TEXEL_AW = $clog2(TEXEL_DEPTH);
   localparam int CMP_W    = 18;   // wide enough for any address and the depth itself
   localparam int NUM_W    = 23;   // offset times texture size
   localparam int REM_W    = 24;
   localparam int Q_W      = 7;    // texel coordinate
   localparam int ADDR_W   = 14;   // row times width plus column

   typedef enum logic [2:0] {
      REG_SPRITE_LEFT    = 3'd0,
      REG_SPRITE_RIGHT   = 3'd1,
      REG_SPRITE_TOP     = 3'd2,
      REG_SPRITE_BOTTOM  = 3'd3,
      REG_TEXTURE_WIDTH  = 3'd4,
      REG_TEXTURE_HEIGHT = 3'd5,
      REG_BRIGHTNESS     = 3'd6
   } reg_index_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   typedef struct packed {
      logic        vld;
      logic        draw;
      logic        ok;
      logic [10:0] px;
      logic [10:0] py;
      logic [11:0] tidx;
      logic [31:0] tval;
   } meta_type;

   typedef struct packed {
      logic                adv;
      logic                we;
      logic                re;
      logic [TEXEL_AW-1:0] waddr;
      logic [TEXEL_AW-1:0] raddr;
   } mem_ctl_type;

endpackage

@@ src/spsb_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spsb_req_if: request channel
// Texel loads and pixel draws with valid / ready.
// ---------------------------------------------------------------------------
interface spsb_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [11:0] texel_index;
   logic [31:0] texel_value;
   logic [10:0] pixel_x;
   logic [10:0] pixel_y;
   logic [11:0] window_left;
   logic [11:0] window_right;
   logic [11:0] window_top;
   logic [11:0] window_bottom;

   modport source (output valid, req_type, texel_index, texel_value, pixel_x, pixel_y,
                   window_left, window_right, window_top, window_bottom, input ready);
   modport sink   (input valid, req_type, texel_index, texel_value, pixel_x, pixel_y,
                   window_left, window_right, window_top, window_bottom, output ready);
endinterface

@@ src/spsb_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spsb_rsp_if: result channel
// One result per draw with valid / ready.
// ---------------------------------------------------------------------------
interface spsb_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_pixel;
   logic [10:0] out_x;
   logic [10:0] out_y;
   logic [31:0] out_color;

   modport source (output valid, write_pixel, out_x, out_y, out_color, input ready);
   modport sink   (input valid, write_pixel, out_x, out_y, out_color, output ready);
endinterface

@@ src/spsb_divider.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spsb_divider: pipelined texel coordinate divider
// Restoring division, one quotient bit per stage, Q_W stages.
// ---------------------------------------------------------------------------
module spsb_divider
   import spsb_pkg::*;
(
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num,
   input  logic [15:0]      den,
   output logic [Q_W-1:0]   quot
);

   logic [REM_W-1:0] rem_ff [Q_W];
   logic [REM_W-1:0] rem_in [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [Q_W-1:0]   q_in   [Q_W];
   logic [15:0]      den_ff [Q_W];
   logic [15:0]      den_in [Q_W];

   always_comb begin
      logic [REM_W-1:0] r;
      logic [Q_W-1:0]   q;
      logic [15:0]      d;
      logic [REM_W-1:0] sh;
      for (int i = 0; i < Q_W; i++) begin
         r  = (i == 0) ? REM_W'(num) : rem_ff[(i == 0) ? 0 : i - 1];
         q  = (i == 0) ? '0 : q_ff[(i == 0) ? 0 : i - 1];
         d  = (i == 0) ? den : den_ff[(i == 0) ? 0 : i - 1];
         sh = REM_W'(d) << (Q_W - 1 - i);
         if (r >= sh) begin
            r = r - sh;
            q[Q_W-1-i] = 1'b1;
         end
         rem_in[i] = r;
         q_in[i]   = q;
         den_in[i] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Q_W; i++) begin
            rem_ff[i] <= rem_in[i];
            q_ff[i]   <= q_in[i];
            den_ff[i] <= den_in[i];
         end
      end
   end

   assign quot = q_ff[Q_W-1];

endmodule

@@ src/spsb_texel_mem.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spsb_texel_mem: texel store
// One write and one registered read per cycle, held while stalled.
// ---------------------------------------------------------------------------
module spsb_texel_mem
   import spsb_pkg::*;
(
   input  logic        clock,
   input  mem_ctl_type ctl,
   input  logic [31:0] wdata,
   output logic [31:0] rdata
);

   logic [31:0] store_ff [TEXEL_DEPTH];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.adv && ctl.we) begin
         store_ff[ctl.waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv && ctl.re) begin
         rdata_ff <= store_ff[ctl.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/spsb_shade.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spsb_shade: brightness scaler
// Scales each 8-bit channel by a Q1.8 factor with saturation.
// ---------------------------------------------------------------------------
module spsb_shade
   import spsb_pkg::*;
(
   input  logic [31:0] color,
   input  logic [8:0]  brightness,
   output logic [31:0] scaled
);

   always_comb begin
      logic [16:0] prod;
      for (int c = 0; c < 4; c++) begin
         prod = 17'(color[c*8 +: 8]) * 17'(brightness);
         scaled[c*8 +: 8] = prod[16] ? 8'hff : prod[15:8];
      end
   end

endmodule

@@ src/sprite_scaled_blit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_scaled_blit: scaled sprite blitter with transparent colour
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The texel store port and the 7-stage divider are pipelined to keep that rate.
// Loads produce no result and write the store in pipeline order with draws.
// Reset clears valid flags and sprite bounds, presets texture size and brightness;
// the texel store is not cleared.
// ---------------------------------------------------------------------------
module sprite_scaled_blit
   import spsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spsb_req_if.sink    req_chan,
   spsb_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic signed [15:0] sl_ff, sr_ff, st_ff, sb_ff;
   logic [6:0]         tw_ff, th_ff;
   logic [8:0]         br_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_ff <= '0;
         sr_ff <= '0;
         st_ff <= '0;
         sb_ff <= '0;
         tw_ff <= 7'd64;
         th_ff <= 7'd64;
         br_ff <= 9'd256;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_SPRITE_LEFT:    sl_ff <= csr_data;
            REG_SPRITE_RIGHT:   sr_ff <= csr_data;
            REG_SPRITE_TOP:     st_ff <= csr_data;
            REG_SPRITE_BOTTOM:  sb_ff <= csr_data;
            REG_TEXTURE_WIDTH:  tw_ff <= csr_data[6:0];
            REG_TEXTURE_HEIGHT: th_ff <= csr_data[6:0];
            REG_BRIGHTNESS:     br_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_valid_ff;
   assign adv = !(out_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = adv;

   // stage a: clip test and offsets
   meta_type    a_in, a_ff;
   logic [15:0] offx_in, offy_in, spanx_in, spany_in;
   logic [15:0] offx_ff, offy_ff, spanx_ff, spany_ff;

   always_comb begin
      logic signed [16:0] pxs, pys, slx, srx, stx, sbx;
      logic               in_x, in_y;
      pxs = signed'({6'b0, req_chan.pixel_x});
      pys = signed'({6'b0, req_chan.pixel_y});
      slx = 17'(sl_ff);
      srx = 17'(sr_ff);
      stx = 17'(st_ff);
      sbx = 17'(sb_ff);
      in_x = (pxs >= slx) && (pxs < srx)
          && ({1'b0, req_chan.pixel_x} >= req_chan.window_left)
          && ({1'b0, req_chan.pixel_x} <  req_chan.window_right)
          && ({1'b0, req_chan.pixel_x} <  12'(SCREEN_WIDTH));
      in_y = (pys >= stx) && (pys < sbx)
          && ({1'b0, req_chan.pixel_y} >= req_chan.window_top)
          && ({1'b0, req_chan.pixel_y} <  req_chan.window_bottom)
          && ({1'b0, req_chan.pixel_y} <  12'(SCREEN_HEIGHT));
      a_in.vld  = req_chan.valid;
      a_in.draw = (req_chan.req_type == REQ_DRAW);
      a_in.ok   = (req_chan.req_type == REQ_DRAW) ? (in_x && in_y)
                : (CMP_W'(req_chan.texel_index) < CMP_W'(TEXEL_DEPTH));
      a_in.px   = req_chan.pixel_x;
      a_in.py   = req_chan.pixel_y;
      a_in.tidx = req_chan.texel_index;
      a_in.tval = req_chan.texel_value;
      offx_in   = 16'(pxs - slx);
      offy_in   = 16'(pys - stx);
      spanx_in  = 16'(srx - slx);
      spany_in  = 16'(sbx - stx);
   end

   // stage b: offset times texture size
   meta_type         b_ff;
   logic [NUM_W-1:0] nx_ff, ny_ff;
   logic [15:0]      dx_ff, dy_ff;

   // divider side-band
   meta_type d_ff [Q_W];
   logic [Q_W-1:0] tx, ty;

   // stage c: texel address
   meta_type          c_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [Q_W-1:0]    tx_ff, ty_ff;

   // stage m: store access, stage o: output
   meta_type m_in, m_ff;
   logic     c_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
         b_ff.vld <= 1'b0;
         c_ff.vld <= 1'b0;
         m_ff.vld <= 1'b0;
         for (int i = 0; i < Q_W; i++) d_ff[i].vld <= 1'b0;
      end else if (adv) begin
         a_ff     <= a_in;
         offx_ff  <= offx_in;
         offy_ff  <= offy_in;
         spanx_ff <= spanx_in;
         spany_ff <= spany_in;
         b_ff     <= a_ff;
         nx_ff    <= NUM_W'(offx_ff) * NUM_W'(tw_ff);
         ny_ff    <= NUM_W'(offy_ff) * NUM_W'(th_ff);
         dx_ff    <= spanx_ff;
         dy_ff    <= spany_ff;
         d_ff[0]  <= b_ff;
         for (int i = 1; i < Q_W; i++) d_ff[i] <= d_ff[i-1];
         c_ff     <= d_ff[Q_W-1];
         tx_ff    <= tx;
         ty_ff    <= ty;
         addr_ff  <= ADDR_W'(ty) * ADDR_W'(tw_ff) + ADDR_W'(tx);
         m_ff     <= m_in;
      end
   end

   spsb_divider u_div_x (.clock(clock), .adv(adv), .num(nx_ff), .den(dx_ff), .quot(tx));
   spsb_divider u_div_y (.clock(clock), .adv(adv), .num(ny_ff), .den(dy_ff), .quot(ty));

   assign c_ok = c_ff.draw
      ? (c_ff.ok && (tx_ff < tw_ff) && (ty_ff < th_ff)
         && (CMP_W'(addr_ff) < CMP_W'(TEXEL_DEPTH)))
      : c_ff.ok;

   always_comb begin
      m_in    = c_ff;
      m_in.ok = c_ok;
   end

   mem_ctl_type mem_ctl;
   logic [31:0] texel;
   always_comb begin
      mem_ctl.adv   = adv;
      mem_ctl.we    = c_ff.vld && !c_ff.draw && c_ff.ok;
      mem_ctl.re    = c_ff.vld && c_ff.draw;
      mem_ctl.waddr = TEXEL_AW'(c_ff.tidx);
      mem_ctl.raddr = TEXEL_AW'(addr_ff);
   end

   spsb_texel_mem u_mem (.clock(clock), .ctl(mem_ctl), .wdata(c_ff.tval), .rdata(texel));

   logic [31:0] scaled;
   spsb_shade u_shade (.color(texel), .brightness(br_ff), .scaled(scaled));

   logic        wp_ff;
   logic [10:0] ox_ff, oy_ff;
   logic [31:0] oc_ff;
   logic        hit;
   assign hit = m_ff.ok && (texel != 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= m_ff.vld && m_ff.draw;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wp_ff <= hit;
         ox_ff <= m_ff.px;
         oy_ff <= m_ff.py;
         oc_ff <= hit ? scaled : 32'd0;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.write_pixel = wp_ff;
   assign rsp_chan.out_x       = ox_ff;
   assign rsp_chan.out_y       = oy_ff;
   assign rsp_chan.out_color   = oc_ff;

   a_blank_color: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !wp_ff |-> oc_ff == 32'd0)
      else $error("transparent result carries colour");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> a_ff.vld)
      else $error("transferred request lost at first stage");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff)
      else $error("waiting result dropped");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      adv && m_ff.vld && !m_ff.draw |=> !out_valid_ff)
      else $error("load produced a result");

endmodule

@@ dv/sprite_scaled_blit_check.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_scaled_blit_check: pixel predictor and result checker
// Watches the request, result and register ports, keeps its own texel store
// and registers, works out each draw's pixel and compares it in order.
// ---------------------------------------------------------------------------
module sprite_scaled_blit_check
   import spsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   spsb_req_if         req_chan,
   spsb_rsp_if         rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          pending,
   output int          mismatches
);

   typedef struct packed {
      logic        write_pixel;
      logic [10:0] out_x;
      logic [10:0] out_y;
      logic [31:0] out_color;
   } pixel_result_type;

   logic [31:0]      texels [TEXEL_DEPTH];
   int               sp_left, sp_right, sp_top, sp_bottom;
   int unsigned      tex_w, tex_h, bright;
   pixel_result_type expected_pixels [$];

   function automatic int imax3(int a, int b, int c);
      int m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic int imin3(int a, int b, int c);
      int m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic pixel_result_type shade_pixel(logic [10:0] px, logic [10:0] py,
                                                    logic [11:0] wl, logic [11:0] wr,
                                                    logic [11:0] wt, logic [11:0] wb);
      pixel_result_type r;
      int               xi, yi;
      int unsigned      spanx, spany, tx, ty, addr, ch;
      logic [31:0]      c;
      xi = int'(px);
      yi = int'(py);
      r = '0;
      r.out_x = px;
      r.out_y = py;
      if (xi >= imax3(sp_left, int'(wl), 0) && xi < imin3(sp_right, int'(wr), SCREEN_WIDTH) &&
          yi >= imax3(sp_top, int'(wt), 0) && yi < imin3(sp_bottom, int'(wb), SCREEN_HEIGHT)) begin
         spanx = sp_right - sp_left;
         spany = sp_bottom - sp_top;
         tx = (xi - sp_left) * tex_w / spanx;
         ty = (yi - sp_top) * tex_h / spany;
         if (tx < tex_w && ty < tex_h) begin
            addr = ty * tex_w + tx;
            if (addr < TEXEL_DEPTH) begin
               c = texels[addr];
               if (c != 0) begin
                  r.write_pixel = 1'b1;
                  for (int sh = 0; sh < 32; sh += 8) begin
                     ch = ((c >> sh) & 32'hFF) * bright >> 8;
                     if (ch > 255) ch = 255;
                     r.out_color[sh +: 8] = ch[7:0];
                  end
               end
            end
         end
      end
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         if (mismatches < 10)
            $display("mismatch on %s: expected %h, got %h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type e;
      if (reset) begin
         sp_left = 0; sp_right = 0; sp_top = 0; sp_bottom = 0;
         tex_w = 64; tex_h = 64; bright = 256;
         foreach (texels[i]) texels[i] = '0;
         expected_pixels.delete();
         mismatches = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SPRITE_LEFT:    sp_left   = int'($signed(csr_data));
               REG_SPRITE_RIGHT:   sp_right  = int'($signed(csr_data));
               REG_SPRITE_TOP:     sp_top    = int'($signed(csr_data));
               REG_SPRITE_BOTTOM:  sp_bottom = int'($signed(csr_data));
               REG_TEXTURE_WIDTH:  tex_w     = 32'(csr_data[6:0]);
               REG_TEXTURE_HEIGHT: tex_h     = 32'(csr_data[6:0]);
               REG_BRIGHTNESS:     bright    = 32'(csr_data[8:0]);
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.req_type == REQ_LOAD) begin
               if (int'(req_chan.texel_index) < TEXEL_DEPTH)
                  texels[req_chan.texel_index] = req_chan.texel_value;
            end else begin
               expected_pixels.push_back(shade_pixel(req_chan.pixel_x, req_chan.pixel_y,
                  req_chan.window_left, req_chan.window_right,
                  req_chan.window_top, req_chan.window_bottom));
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected pixel transfer at x %0d y %0d",
                           rsp_chan.out_x, rsp_chan.out_y);
               mismatches++;
            end else begin
               e = expected_pixels.pop_front();
               compare_field("write_pixel", 32'(e.write_pixel), 32'(rsp_chan.write_pixel));
               compare_field("out_x", 32'(e.out_x), 32'(rsp_chan.out_x));
               compare_field("out_y", 32'(e.out_y), 32'(rsp_chan.out_y));
               compare_field("out_color", e.out_color, rsp_chan.out_color);
            end
         end
      end
      pending = expected_pixels.size();
   end

endmodule

@@ dv/sprite_scaled_blit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_scaled_blit_test: testbench top of the scaled sprite blitter
// Runs register settings from directed extremes to random sprites, loads
// each texture, draws pixels with random gaps and stalls, and reports.
// ---------------------------------------------------------------------------
module sprite_scaled_blit_test;
   import spsb_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   int          pending;
   int          mismatches;
   bit          no_idle;
   int          stall_left;
   int          cur_left, cur_right, cur_top, cur_bottom;

   spsb_req_if req_chan ();
   spsb_rsp_if rsp_chan ();

   sprite_scaled_blit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sprite_scaled_blit_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .pending    (pending),
      .mismatches (mismatches)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // result side stalls after a transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            stall_left = no_idle ? 0 : $urandom_range(0, 19);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_item(logic typ, logic [11:0] idx, logic [31:0] val,
                            logic [10:0] px, logic [10:0] py,
                            logic [11:0] wl, logic [11:0] wr,
                            logic [11:0] wt, logic [11:0] wb);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= typ;
      req_chan.texel_index   <= idx;
      req_chan.texel_value   <= val;
      req_chan.pixel_x       <= px;
      req_chan.pixel_y       <= py;
      req_chan.window_left   <= wl;
      req_chan.window_right  <= wr;
      req_chan.window_top    <= wt;
      req_chan.window_bottom <= wb;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic draw(logic [10:0] px, logic [10:0] py, logic [11:0] wl,
                       logic [11:0] wr, logic [11:0] wt, logic [11:0] wb);
      send_item(REQ_DRAW, 12'($urandom), $urandom, px, py, wl, wr, wt, wb);
   endtask

   // waits until every pixel is back and loads have left the pipeline
   task automatic drain();
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic setup_sprite(int l, int r, int t, int b, int tw, int th, int br);
      logic [15:0] vals [8];
      drain();
      vals = '{l[15:0], r[15:0], t[15:0], b[15:0], tw[15:0], th[15:0], br[15:0],
               16'($urandom)};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= (i == 7) ? REG_UNUSED : 3'(i);
         csr_data  <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_left = l; cur_right = r; cur_top = t; cur_bottom = b;
      // every texel the draws can reach gets written, some as transparent
      for (int a = 0; a < (tw & 127) * (th & 127) && a < TEXEL_DEPTH; a++)
         send_item(REQ_LOAD, 12'(a), ($urandom_range(0, 6) == 0) ? 32'h0 : $urandom,
                   11'($urandom), 11'($urandom), 12'($urandom), 12'($urandom),
                   12'($urandom), 12'($urandom));
      repeat (3)
         send_item(REQ_LOAD, 12'($urandom), $urandom, 11'($urandom), 11'($urandom),
                   12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
   endtask

   function automatic int pick_coord(int lo, int hi);
      int a, b;
      a = (lo - 2 < 0) ? 0 : ((lo - 2 > 2047) ? 2047 : lo - 2);
      b = (hi + 1 < 0) ? 0 : ((hi + 1 > 2047) ? 2047 : hi + 1);
      if (a > b || $urandom_range(0, 7) == 0) return $urandom_range(0, 2047);
      return $urandom_range(a, b);
   endfunction

   task automatic random_draws(int n);
      int px, py;
      logic [11:0] wl, wr, wt, wb;
      repeat (n) begin
         px = pick_coord(cur_left, cur_right);
         py = pick_coord(cur_top, cur_bottom);
         if ($urandom_range(0, 3) != 0) begin
            wl = 12'($urandom_range(0, px));
            wr = 12'($urandom_range(px + 1, 2048));
            wt = 12'($urandom_range(0, py));
            wb = 12'($urandom_range(py + 1, 2048));
         end else begin
            wl = 12'($urandom); wr = 12'($urandom); wt = 12'($urandom); wb = 12'($urandom);
         end
         draw(11'(px), 11'(py), wl, wr, wt, wb);
      end
   endtask

   initial begin
      int l, w, t, h, tw, th, br;
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      no_idle        = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.req_type      <= REQ_LOAD;
      req_chan.texel_index   <= '0;
      req_chan.texel_value   <= '0;
      req_chan.pixel_x       <= '0;
      req_chan.pixel_y       <= '0;
      req_chan.window_left   <= '0;
      req_chan.window_right  <= '0;
      req_chan.window_top    <= '0;
      req_chan.window_bottom <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset state: empty sprite draws nothing
      cur_left = 0; cur_right = 0; cur_top = 0; cur_bottom = 0;
      draw(0, 0, 0, 2048, 0, 2048);
      draw(2047, 2047, 4095, 4095, 4095, 4095);

      // sprite fills the screen
      setup_sprite(0, 1024, 0, 768, 8, 8, 256);
      draw(0, 0, 0, 2048, 0, 2048);
      draw(1023, 767, 0, 2048, 0, 2048);
      draw(1024, 10, 0, 2048, 0, 2048);
      draw(10, 768, 0, 2048, 0, 2048);
      draw(500, 300, 500, 501, 300, 301);
      draw(500, 300, 501, 4095, 0, 4095);
      draw(500, 300, 0, 500, 0, 4095);

      // widest sprite, wide texture, saturating brightness
      setup_sprite(-32768, 32767, -32768, 32767, 127, 1, 511);
      draw(0, 0, 0, 2048, 0, 2048);
      draw(1023, 767, 0, 4095, 0, 4095);
      draw(2047, 2047, 0, 4095, 0, 4095);

      // zero texture size, zero brightness
      setup_sprite(10, 200, 10, 200, 0, 5, 0);
      draw(50, 50, 0, 2048, 0, 2048);
      setup_sprite(10, 200, 10, 200, 5, 0, 0);
      draw(50, 50, 0, 2048, 0, 2048);

      // narrow tall texture, sprite off the top left
      setup_sprite(-20, 44, -30, 34, 1, 64, 128);
      draw(0, 0, 0, 2048, 0, 2048);
      draw(43, 33, 0, 2048, 0, 2048);
      random_draws(20);

      setup_sprite(100, 164, 200, 202, 64, 2, 1);
      random_draws(20);

      // inverted sprite
      setup_sprite(500, 400, 300, 200, 4, 4, 256);
      draw(450, 250, 0, 2048, 0, 2048);
      draw(500, 300, 0, 2048, 0, 2048);

      for (int ph = 0; ph < 6; ph++) begin
         l = $urandom_range(0, 1300) - 200;
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000) : $urandom_range(1, 600);
         t = $urandom_range(0, 1000) - 200;
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000) : $urandom_range(1, 500);
         if (l + w > 32767) w = 32767 - l;
         if (t + h > 32767) h = 32767 - t;
         tw = $urandom_range(1, 8);
         th = $urandom_range(1, 8);
         if (ph == 3) tw = 0;
         br = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(0, 511);
         no_idle = (ph % 3 == 2);
         setup_sprite(l, l + w, t, t + h, tw, th, br);
         random_draws(30);
      end
      no_idle = 1'b0;
      drain();

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
